// ===== hdl/usb_midi_descriptor_scanner_macros.svh =====
// assertion macros for the usb midi descriptor scanner
// used by the top level; no other dependencies
`ifndef USB_MIDI_DESCRIPTOR_SCANNER_MACROS_SVH
`define USB_MIDI_DESCRIPTOR_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usb midi descriptor scanner check failed");
// next-cycle implication
`define MDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usb midi descriptor scanner check failed");
`else
`define MDS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/usb_mds_pkg.sv =====
// types and constants for the usb midi descriptor scanner
// no dependencies
package usb_mds_pkg;

  // descriptor types and field codes
  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] AUDIO_CLASS    = 8'h01;
  localparam logic [7:0] MIDI_SUBCLASS  = 8'h03;
  localparam logic [1:0] XFER_MASK      = 2'h3;
  localparam logic [1:0] XFER_BULK      = 2'h2;
  localparam int         DIR_IN_BIT     = 7;
  localparam logic [15:0] PACKET_RESET  = 16'd64;

  // byte offsets inside a descriptor
  localparam logic [7:0] POS_LENGTH   = 8'd0;
  localparam logic [7:0] POS_TYPE     = 8'd1;
  localparam logic [7:0] POS_IF_NUM   = 8'd2;
  localparam logic [7:0] POS_IF_CLASS = 8'd5;
  localparam logic [7:0] POS_IF_SUB   = 8'd6;
  localparam logic [7:0] POS_EP_ADDR  = 8'd2;
  localparam logic [7:0] POS_EP_ATTR  = 8'd3;
  localparam logic [7:0] POS_EP_LOW   = 8'd4;
  localparam logic [7:0] POS_EP_HIGH  = 8'd5;

  // result kinds
  localparam logic KIND_CLAIM  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  interface_number;
    logic        midi_found;
    logic [7:0]  endpoint_address;
    logic [15:0] max_packet;
    logic        ready_res;
    logic        last;
  } out_item_t;

  // results produced by one scan step
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } step_res_t;

  // queue status towards the input side
  typedef struct packed {
    logic              room;
    logic [QCNT_W-1:0] fill;
  } q_status_t;

endpackage

// ===== hdl/usb_midi_descriptor_scanner.sv =====
// USB MIDI descriptor scanner. Descriptor bytes are taken one per clock
// into an input register; a held byte is scanned once the queue has room and
// its results (none, a claim, a report, or a claim then a report) go into
// a four-entry result queue. The scanner keeps taking one byte per cycle as
// long as the queue has room for two results; a byte that raises both a
// claim and a final report needs two output transfers, so the output side
// sets the rate then. No configuration and no clearing pass after reset.
// depends on usb_mds_pkg, usb_mds_scan, usb_mds_outq and the macros header
`include "usb_midi_descriptor_scanner_macros.svh"

module usb_midi_descriptor_scanner import usb_mds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      desc_valid,
  output logic      desc_stall,
  input  in_item_t  desc_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      hold_valid;
  in_item_t  hold_item;
  logic      step;
  step_res_t step_res;
  q_status_t q_status;

  // a held byte is scanned once the queue has room for two results
  assign step       = hold_valid && q_status.room;
  assign desc_stall = hold_valid && !q_status.room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (desc_valid && !desc_stall) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && !desc_stall) begin
      hold_item <= desc_item;
    end
  end

  usb_mds_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (hold_item),
    .res  (step_res)
  );

  usb_mds_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .res       (step_res),
    .status    (q_status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // checks
  `MDS_ASSERT_NOW(a_step_room, clk, rst, step, q_status.fill <= QCNT_W'(QDEPTH - 2))
  `MDS_ASSERT_NOW(a_report_last, clk, rst, res_valid && res_item.kind == KIND_REPORT, res_item.last)
  `MDS_ASSERT_NOW(a_claim_found, clk, rst, res_valid && res_item.kind == KIND_CLAIM, res_item.midi_found)
  `MDS_ASSERT_NEXT(a_hold_keeps, clk, rst, hold_valid && !step, hold_valid && $stable(hold_item))

endmodule

// ===== hdl/usb_mds_scan.sv =====
// descriptor scan state and per-byte update
// depends on usb_mds_pkg
module usb_mds_scan import usb_mds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output step_res_t res
);

  logic [7:0]  byte_pos, byte_pos_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  desc_type, desc_type_next;
  logic [7:0]  held_field_a, held_field_a_next;
  logic [7:0]  held_field_b, held_field_b_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic        found_flag, found_flag_next;
  logic        stopped_flag, stopped_flag_next;
  logic [7:0]  midi_interface, midi_interface_next;
  logic [7:0]  midi_endpoint, midi_endpoint_next;
  logic [15:0] endpoint_packet, endpoint_packet_next;

  logic        claim;
  logic [7:0]  b;
  logic [8:0]  pos_inc;
  out_item_t   claim_res, report_res;

  assign b = item.desc_byte;

  // per-byte field extraction
  always_comb begin
    byte_pos_next        = byte_pos;
    desc_length_next     = desc_length;
    desc_type_next       = desc_type;
    held_field_a_next    = held_field_a;
    held_field_b_next    = held_field_b;
    held_low_byte_next   = held_low_byte;
    found_flag_next      = found_flag;
    stopped_flag_next    = stopped_flag;
    midi_interface_next  = midi_interface;
    midi_endpoint_next   = midi_endpoint;
    endpoint_packet_next = endpoint_packet;
    claim                = 1'b0;
    pos_inc              = '0;

    if (!stopped_flag) begin
      if (byte_pos == POS_LENGTH) begin
        desc_length_next = b;
        desc_type_next   = '0;
        if (b == 8'd0) begin
          stopped_flag_next = 1'b1;
        end
      end else if (byte_pos == POS_TYPE) begin
        desc_type_next = b;
      end else if (desc_type == TYPE_INTERFACE) begin
        if (byte_pos == POS_IF_NUM) begin
          held_field_a_next = b;
        end else if (byte_pos == POS_IF_CLASS) begin
          held_field_b_next = b;
        end else if (byte_pos == POS_IF_SUB) begin
          held_low_byte_next = b;
          if (held_field_b == AUDIO_CLASS && b == MIDI_SUBCLASS) begin
            midi_interface_next = held_field_a;
            found_flag_next     = 1'b1;
            claim               = 1'b1;
          end
        end
      end else if (desc_type == TYPE_ENDPOINT) begin
        if (byte_pos == POS_EP_ADDR) begin
          held_field_a_next = b;
        end else if (byte_pos == POS_EP_ATTR) begin
          held_field_b_next = b;
        end else if (byte_pos == POS_EP_LOW) begin
          held_low_byte_next = b;
        end else if (byte_pos == POS_EP_HIGH) begin
          if (found_flag && (held_field_b[1:0] & XFER_MASK) == XFER_BULK &&
              held_field_a[DIR_IN_BIT]) begin
            midi_endpoint_next   = held_field_a;
            endpoint_packet_next = {b, held_low_byte};
          end
        end
      end
      // advance within the descriptor, wrap at its length
      if (!stopped_flag_next) begin
        pos_inc = {1'b0, byte_pos} + 9'd1;
        if (pos_inc >= {1'b0, desc_length_next}) begin
          byte_pos_next = '0;
        end else begin
          byte_pos_next = pos_inc[7:0];
        end
      end
    end

    // claim result carries the endpoint fields as they stand
    claim_res.kind             = KIND_CLAIM;
    claim_res.interface_number = held_field_a;
    claim_res.midi_found       = 1'b1;
    claim_res.endpoint_address = midi_endpoint_next;
    claim_res.max_packet       = endpoint_packet_next;
    claim_res.ready_res        = (midi_endpoint_next != 8'd0);
    claim_res.last             = !item.last_byte;

    // report uses the state after this byte
    report_res.kind             = KIND_REPORT;
    report_res.interface_number = midi_interface_next;
    report_res.midi_found       = found_flag_next;
    report_res.endpoint_address = midi_endpoint_next;
    report_res.max_packet       = endpoint_packet_next;
    report_res.ready_res        = found_flag_next && (midi_endpoint_next != 8'd0);
    report_res.last             = 1'b1;

    // end of set clears the scan for the next one, but for midi_interface and endpoint_packet
    if (item.last_byte) begin
      byte_pos_next      = '0;
      desc_length_next   = '0;
      desc_type_next     = '0;
      held_field_a_next  = '0;
      held_field_b_next  = '0;
      held_low_byte_next = '0;
      found_flag_next    = 1'b0;
      stopped_flag_next  = 1'b0;
      midi_endpoint_next = '0;
    end

    res.count  = {1'b0, claim} + {1'b0, item.last_byte};
    res.first  = claim ? claim_res : report_res;
    res.second = report_res;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos        <= '0;
      desc_length     <= '0;
      desc_type       <= '0;
      held_field_a    <= '0;
      held_field_b    <= '0;
      held_low_byte   <= '0;
      found_flag      <= 1'b0;
      stopped_flag    <= 1'b0;
      midi_interface  <= '0;
      midi_endpoint   <= '0;
      endpoint_packet <= PACKET_RESET;
    end else if (step) begin
      byte_pos        <= byte_pos_next;
      desc_length     <= desc_length_next;
      desc_type       <= desc_type_next;
      held_field_a    <= held_field_a_next;
      held_field_b    <= held_field_b_next;
      held_low_byte   <= held_low_byte_next;
      found_flag      <= found_flag_next;
      stopped_flag    <= stopped_flag_next;
      midi_interface  <= midi_interface_next;
      midi_endpoint   <= midi_endpoint_next;
      endpoint_packet <= endpoint_packet_next;
    end
  end

endmodule

// ===== hdl/usb_mds_outq.sv =====
// small result queue: takes up to two results a cycle, gives one while res_stall is low
// depends on usb_mds_pkg
module usb_mds_outq import usb_mds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_res_t res,
  output q_status_t status,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  out_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill, fill_next;
  logic [QCNT_W-1:0] push_cnt;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_inc;

  assign push_cnt   = push ? QCNT_W'(res.count) : '0;
  assign pop        = res_valid && !res_stall;
  assign wr_ptr_inc = wr_ptr + QPTR_W'(1);
  assign fill_next  = fill + push_cnt - QCNT_W'(pop);

  assign res_valid     = (fill != '0);
  assign res_item      = slots[rd_ptr];
  assign status.fill   = fill;
  assign status.room   = (fill <= QCNT_W'(QDEPTH - 2));

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push && res.count != 2'd0) begin
      slots[wr_ptr] <= res.first;
    end
    if (push && res.count == 2'd2) begin
      slots[wr_ptr_inc] <= res.second;
    end
  end

endmodule
